@@ hw/rtl/handle_slot_map_macros.svh @@
// assertion helpers for the checker file
`ifndef HANDLE_SLOT_MAP_MACROS_SVH
`define HANDLE_SLOT_MAP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define HSM_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define HSM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hsm_pkg.sv @@
package hsm_pkg;

  localparam int unsigned SLOTS_DEF     = 1024;
  localparam int unsigned SLOT_BITS_DEF = 16;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } hsm_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } hsm_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_APPEND,
    S_LOOKUP,
    S_RM_CHECK,
    S_RM_MOVE,
    S_RM_FIX,
    S_EMIT
  } hsm_state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
  } hsm_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] new_handle;
    logic                present;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    moved_from;
    logic [POS_W-1:0]    moved_to;
    logic [COUNT_W-1:0]  live_count;
  } hsm_rsp_t;

endpackage

@@ hw/rtl/hsm_ram.sv @@
module hsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/handle_slot_map.sv @@
// channel   direction  handshake              payload
// --------  ---------  ---------------------  ----------------------------------
// in        in         in_valid_i/in_stall_o  in_req_i   (op, handle)
// out       out        out_valid_o/out_stall_i out_rsp_o (status .. live_count)
// cfg       in         cfg_valid_i/cfg_ready_o cfg_data_i (generation step)
//
// append runs S_APPEND, lookup S_LOOKUP, remove S_RM_CHECK, S_RM_MOVE, S_RM_FIX
// (slot, tail slot and moved slot read in turn through the one slot table
// port); a miss ends a remove at S_RM_CHECK; a full append, an out-of-range
// slot or an unused op skips to S_EMIT; after reset a clearing pass fills the
// slot table, with in_stall_o high throughout; cfg writes are taken at any time
// a response waiting in the output register stalls only the last step
module handle_slot_map
  import hsm_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned SLOT_BITS = SLOT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsm_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsm_rsp_t          out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [STEP_W-1:0] cfg_data_i
);

  localparam int unsigned SW = $clog2(SLOTS);      // slot / position index
  localparam int unsigned CW = $clog2(SLOTS + 1);  // counts up to SLOTS
  localparam int unsigned GW = HANDLE_W - SLOT_BITS; // generation bits
  localparam int unsigned EW = 1 + GW + SW + CW;

  // one slot table word; the slot bits of a stored handle always equal the
  // slot number, so only the generation is kept
  typedef struct packed {
    logic          live;
    logic [GW-1:0] gen;
    logic [SW-1:0] pos;
    logic [CW-1:0] nxt;
  } slot_ent_t;

  hsm_state_e state_q, state_d, acc_state;

  logic [SW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     live_q, live_d, head_q, head_d;
  logic [SW-1:0]     tail_q, tail_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [GW-1:0] hgen_q, hgen_d;
  logic [SW-1:0] sidx_q, sidx_d, pos_q, pos_d, ms_q, ms_d;
  logic          empty_q, empty_d;

  hsm_rsp_t res_q, res_d, out_q, out_d;
  logic     out_valid_q, out_valid_d;

  // slot table port
  logic          slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  slot_ent_t     slot_wdata, slot_rd;
  logic [EW-1:0] slot_rdata;

  // same-address write/read bypass for the slot table
  logic          byp_q, byp_d;
  slot_ent_t     byp_data_q;

  // dense array: slot number held at each dense position
  logic          dense_we;
  logic [SW-1:0] dense_waddr, dense_wdata, dense_raddr, dense_rdata;

  logic [SLOT_BITS-1:0] req_slot;
  logic [SW-1:0]        req_idx;
  logic                 req_in_range, full, out_free, can_take, accept, ent_match;
  logic [GW-1:0]        app_gen;
  logic [CW-1:0]        live_dec, live_inc;

  hsm_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  hsm_ram #(
    .WIDTH(SW),
    .DEPTH(SLOTS)
  ) u_dense_ram (
    .clk_i  (clk_i),
    .we_i   (dense_we),
    .waddr_i(dense_waddr),
    .wdata_i(dense_wdata),
    .raddr_i(dense_raddr),
    .rdata_o(dense_rdata)
  );

  // request decode
  assign req_slot     = in_req_i.handle[SLOT_BITS-1:0];
  assign req_idx      = SW'(req_slot);
  assign req_in_range = HANDLE_W'(req_slot) < HANDLE_W'(SLOTS);

  // table full, or free list run dry
  assign full = (live_q >= CW'(SLOTS)) || (head_q >= CW'(SLOTS));

  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_take   = (state_q == S_IDLE) || ((state_q == S_EMIT) && out_free);
  assign accept     = in_valid_i && can_take;
  assign in_stall_o = !can_take;

  assign slot_rd   = byp_q ? byp_data_q : slot_ent_t'(slot_rdata);
  assign ent_match = slot_rd.live && (slot_rd.gen == hgen_q);
  assign app_gen   = slot_rd.gen + GW'(step_q);
  assign live_dec  = live_q - CW'(1);
  assign live_inc  = live_q + CW'(1);

  assign byp_d = slot_we && (slot_waddr == slot_raddr);

  assign cfg_ready_o = 1'b1;
  assign step_d      = cfg_valid_i ? cfg_data_i : step_q;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // first working state of an accepted request
  always_comb begin
    case (in_req_i.op)
      OP_APPEND: acc_state = full ? S_EMIT : S_APPEND;
      OP_REMOVE: acc_state = req_in_range ? S_RM_CHECK : S_EMIT;
      OP_LOOKUP: acc_state = req_in_range ? S_LOOKUP : S_EMIT;
      default:   acc_state = S_EMIT;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = acc_state;
        end
      end
      S_APPEND:   state_d = S_EMIT;
      S_LOOKUP:   state_d = S_EMIT;
      S_RM_CHECK: state_d = ent_match ? S_RM_MOVE : S_EMIT;
      S_RM_MOVE:  state_d = S_RM_FIX;
      S_RM_FIX:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = accept ? acc_state : S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    clr_d       = clr_q;
    live_d      = live_q;
    head_d      = head_q;
    tail_d      = tail_q;
    hgen_d      = hgen_q;
    sidx_d      = sidx_q;
    pos_d       = pos_q;
    ms_d        = ms_q;
    empty_d     = empty_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    slot_we     = 1'b0;
    slot_waddr  = sidx_q;
    slot_wdata  = slot_rd;
    slot_raddr  = sidx_q;
    dense_we    = 1'b0;
    dense_waddr = pos_q;
    dense_wdata = dense_rdata;
    dense_raddr = live_dec[SW-1:0];

    case (state_q)
      S_CLEAR: begin
        // generation zero, not live, free list chained in slot order
        slot_we        = 1'b1;
        slot_waddr     = clr_q;
        slot_wdata     = '0;
        slot_wdata.nxt = CW'(clr_q) + CW'(1);
        clr_d          = clr_q + SW'(1);
      end
      S_APPEND: begin
        slot_we              = 1'b1;
        slot_wdata.live      = 1'b1;
        slot_wdata.gen       = app_gen;
        slot_wdata.pos       = live_q[SW-1:0];
        dense_we             = 1'b1;
        dense_waddr          = live_q[SW-1:0];
        dense_wdata          = sidx_q;
        head_d               = slot_rd.nxt;
        live_d               = live_inc;
        res_d.new_handle     = {app_gen, SLOT_BITS'(sidx_q)};
        res_d.present        = 1'b1;
        res_d.position       = POS_W'(live_q);
        res_d.live_count     = COUNT_W'(live_inc);
      end
      S_LOOKUP: begin
        if (ent_match) begin
          res_d.present  = 1'b1;
          res_d.position = POS_W'(slot_rd.pos);
        end else begin
          res_d.status = ST_MISSING;
        end
      end
      S_RM_CHECK: begin
        if (ent_match) begin
          // retire the slot, fetch the last dense entry and the tail slot
          slot_we         = 1'b1;
          slot_wdata.live = 1'b0;
          pos_d           = slot_rd.pos;
          empty_d         = live_q >= CW'(SLOTS);
          live_d          = live_dec;
          slot_raddr      = tail_q;
        end else begin
          res_d.status = ST_MISSING;
        end
      end
      S_RM_MOVE: begin
        // last entry moves into the hole; link the freed slot behind the tail unless the free list is empty
        dense_we   = 1'b1;
        ms_d       = dense_rdata;
        slot_raddr = dense_rdata;
        if (!empty_q) begin
          slot_we        = 1'b1;
          slot_waddr     = tail_q;
          slot_wdata.nxt = CW'(sidx_q);
        end
      end
      S_RM_FIX: begin
        slot_we          = 1'b1;
        slot_waddr       = ms_q;
        slot_wdata.pos   = pos_q;
        if (empty_q) begin
          head_d = CW'(sidx_q);
        end
        tail_d           = sidx_q;
        res_d.moved_from = POS_W'(live_q);
        res_d.moved_to   = POS_W'(pos_q);
        res_d.live_count = COUNT_W'(live_q);
      end
      S_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // a new request starts its slot read right away
    if (accept) begin
      hgen_d           = in_req_i.handle[HANDLE_W-1:SLOT_BITS];
      res_d            = '0;
      res_d.live_count = COUNT_W'(live_q);
      case (in_req_i.op)
        OP_APPEND: begin
          if (full) begin
            res_d.status = ST_FULL;
          end else begin
            sidx_d     = head_q[SW-1:0];
            slot_raddr = head_q[SW-1:0];
          end
        end
        OP_REMOVE, OP_LOOKUP: begin
          sidx_d     = req_idx;
          slot_raddr = req_idx;
          if (!req_in_range) begin
            res_d.status = ST_MISSING;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      head_q      <= '0;
      tail_q      <= SW'(SLOTS - 1);
      step_q      <= STEP_RESET;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      byp_q       <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hgen_q     <= hgen_d;
    sidx_q     <= sidx_d;
    pos_q      <= pos_d;
    ms_q       <= ms_d;
    empty_q    <= empty_d;
    res_q      <= res_d;
    out_q      <= out_d;
    byp_data_q <= slot_wdata;
  end

endmodule

@@ hw/rtl/hsm_checker.sv @@
`include "handle_slot_map_macros.svh"

module hsm_checker
  import hsm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_i,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input hsm_rsp_t out_rsp_i
);

  logic               in_acc, out_acc;
  logic [1:0]         pend_q, pend_d;
  logic [COUNT_W-1:0] live_seen_q, live_seen_d;

  assign in_acc  = in_valid_i && !in_stall_i;
  assign out_acc = out_valid_i && !out_stall_i;

  // requests taken but not yet answered
  assign pend_d      = pend_q + 2'(in_acc) - 2'(out_acc);
  assign live_seen_d = out_acc ? out_rsp_i.live_count : live_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      live_seen_q <= '0;
    end else begin
      pend_q      <= pend_d;
      live_seen_q <= live_seen_d;
    end
  end

  `HSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_rsp_i), "stalled response changed")

  `HSM_ASSERT_NOW(a_out_owed, clk_i, rst_ni, out_valid_i, pend_q != 2'd0, "response without a request")

  `HSM_ASSERT_NOW(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q != 2'd3, "more than two requests in flight")

  `HSM_ASSERT_NOW(a_live_step, clk_i, rst_ni, out_acc, (out_rsp_i.live_count == live_seen_q) || (out_rsp_i.live_count == live_seen_q + COUNT_W'(1)) || (out_rsp_i.live_count == live_seen_q - COUNT_W'(1)), "live count jumped")

endmodule

bind handle_slot_map hsm_checker u_hsm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_i  (out_rsp_o)
);

@@ verif/tb_handle_slot_map.sv @@
module tb_handle_slot_map;
  import hsm_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int SLOT_BITS = SLOT_BITS_DEF;
  // op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int WATCHDOG = 20000;
  // receiver hold-off that backs the block up into its input
  localparam int HOLD_OFF = 300;

  // block ports; the inputs are driven to known values from time zero
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  hsm_req_t          in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  hsm_rsp_t          out_rsp_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [STEP_W-1:0] cfg_data_i = '0;

  handle_slot_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the handle table, updated as each request is taken
  logic [STEP_W-1:0] gen_step;
  logic [31:0]       slot_hdl   [SLOTS];
  bit                slot_alive [SLOTS];
  int                slot_pos   [SLOTS];
  int                slot_next  [SLOTS];
  logic [31:0]       dense_hdl  [SLOTS];
  int                live_n;
  int                head_slot;
  int                tail_slot;

  // responses owed by the block, oldest first
  hsm_rsp_t pending_rsp_q [$];
  int       fail_count = 0;

  // set by the driver alongside a directed request whose response is typed in
  bit       rsp_typed = 1'b0;
  hsm_rsp_t typed_rsp = '0;

  // shared knobs between the stimulus and the receiver
  bit quiet = 1'b0;   // no gaps and no stalls on either side
  int hold_ask = 0;   // receiver hold-off request, in cycles

  // directed requests; typed rows carry a response read straight off the spec,
  // the others are checked against the shadow table
  typedef struct {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    hsm_rsp_t            rsp;
  } plan_row_t;

  plan_row_t directed_plan [21] = '{
    // empty table: lookups and removes miss, unused op is a no-op
    '{OP_LOOKUP, 32'h0000_0000, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 0}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 0}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
    // slot index just past the table, and the top slot while not live
    '{OP_LOOKUP, 32'h0000_0400, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 0}},
    '{OP_LOOKUP, 32'hFFFF_03FF, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 0}},
    // three appends with the reset step of one
    '{OP_APPEND, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0001_0000, 1, 0, 0, 0, 1}},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0001_0001, 1, 1, 0, 0, 2}},
    '{OP_APPEND, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0001_0002, 1, 2, 0, 0, 3}},
    '{OP_LOOKUP, 32'h0001_0001, 1'b1, '{ST_OK, 0, 1, 1, 0, 0, 3}},
    // stale generation, then a slot that was never handed out
    '{OP_LOOKUP, 32'h0002_0001, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 3}},
    '{OP_LOOKUP, 32'h0001_0003, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 3}},
    // swap-delete from the front, the last entry moves down
    '{OP_REMOVE, 32'h0001_0000, 1'b0, '{ST_OK, 0, 0, 0, 0, 0, 0}},
    '{OP_LOOKUP, 32'h0001_0002, 1'b0, '{ST_OK, 0, 0, 0, 0, 0, 0}},
    // removed handle is gone, a second remove misses
    '{OP_LOOKUP, 32'h0001_0000, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 2}},
    '{OP_REMOVE, 32'h0001_0000, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 2}},
    // removing the last dense entry is a self move
    '{OP_REMOVE, 32'h0001_0001, 1'b1, '{ST_OK, 0, 0, 0, 1, 1, 1}},
    '{OP_REMOVE, 32'h0001_0002, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
    // free list is fifo: the next fresh slot comes before the freed ones
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0001_0003, 1, 0, 0, 0, 1}},
    '{OP_UNUSED, 32'h0000_0000, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 1}},
    '{OP_LOOKUP, 32'h0001_0003, 1'b1, '{ST_OK, 0, 1, 0, 0, 0, 1}},
    '{OP_REMOVE, 32'h0001_0003, 1'b0, '{ST_OK, 0, 0, 0, 0, 0, 0}}
  };

  // slot of a live handle, or SLOTS when the handle is not in the table
  function automatic int locate(logic [31:0] h);
    int s;
    s = int'(h[SLOT_BITS-1:0]);
    if (s >= SLOTS || !slot_alive[s] || slot_hdl[s] != h) return SLOTS;
    return s;
  endfunction

  // apply one request to the shadow table and return the response it owes
  function automatic hsm_rsp_t update_table(hsm_req_t req);
    hsm_rsp_t    rsp;
    int          s;
    int          pos;
    int          last;
    int          ms;
    logic [31:0] mh;
    bit          was_full;
    rsp = '0;
    case (req.op)
      OP_APPEND: begin
        if (live_n >= SLOTS || head_slot >= SLOTS) begin
          rsp.status = ST_FULL;
        end else begin
          // pop the free-list head and bump its generation, wrapping at 32 bits
          s = head_slot;
          head_slot = slot_next[s];
          slot_hdl[s] = slot_hdl[s] + (32'(gen_step) << SLOT_BITS);
          slot_alive[s] = 1'b1;
          slot_pos[s] = live_n;
          dense_hdl[live_n] = slot_hdl[s];
          rsp.new_handle = slot_hdl[s];
          rsp.present = 1'b1;
          rsp.position = POS_W'(live_n);
          live_n++;
        end
      end
      OP_REMOVE: begin
        s = locate(req.handle);
        if (s >= SLOTS) begin
          rsp.status = ST_MISSING;
        end else begin
          was_full = (live_n >= SLOTS);
          live_n--;
          last = live_n;
          pos = slot_pos[s];
          // last dense entry fills the hole and its slot is repointed
          mh = dense_hdl[last];
          dense_hdl[pos] = mh;
          ms = int'(mh[SLOT_BITS-1:0]);
          slot_pos[ms] = pos;
          slot_alive[s] = 1'b0;
          // an empty free list restarts with the freed slot as its head
          if (was_full) begin
            head_slot = s;
          end else begin
            slot_next[tail_slot] = s;
          end
          tail_slot = s;
          rsp.moved_from = POS_W'(last);
          rsp.moved_to = POS_W'(pos);
        end
      end
      OP_LOOKUP: begin
        s = locate(req.handle);
        if (s >= SLOTS) begin
          rsp.status = ST_MISSING;
        end else begin
          rsp.present = 1'b1;
          rsp.position = POS_W'(slot_pos[s]);
        end
      end
      default: ;  // unused op leaves the table alone
    endcase
    rsp.live_count = COUNT_W'(live_n);
    return rsp;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    end
  endtask

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 30);
  endfunction

  // random request: appends at the given share, live handles for most removes
  // and lookups, and a tail of noise (random, stale or unused-op requests)
  function automatic hsm_req_t pick_req(int append_pct);
    hsm_req_t req;
    int       roll;
    roll = $urandom_range(0, 99);
    req.handle = $urandom;
    if (roll < append_pct) begin
      req.op = OP_APPEND;
    end else if (roll >= 92) begin
      case ($urandom_range(0, 2))
        0: req.op = OP_REMOVE;
        1: req.op = OP_LOOKUP;
        default: req.op = OP_UNUSED;
      endcase
      // a live handle with a wrong generation
      if (live_n > 0 && $urandom_range(0, 1) == 1) begin
        req.handle = dense_hdl[$urandom_range(0, live_n - 1)]
                     ^ (32'($urandom_range(1, 65535)) << SLOT_BITS);
      end
    end else begin
      req.op = ($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_LOOKUP;
      if (live_n > 0) req.handle = dense_hdl[$urandom_range(0, live_n - 1)];
    end
    return req;
  endfunction

  // offer one request after a gap; starts and ends on a falling edge,
  // leaving valid high so a back-to-back request needs no drop
  task automatic send_req(hsm_req_t req, int gap);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i = req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every owed response has come back
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  // write the generation step while the block is idle
  task automatic set_step(logic [STEP_W-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gen_step = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // response checker and request predictor, both on the rising edge
  always @(posedge clk_i) begin
    hsm_rsp_t want;
    hsm_rsp_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          flag_error($sformatf("response with none pending: %h", out_rsp_o));
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_rsp_o.status));
          check_field("new_handle", want.new_handle, out_rsp_o.new_handle);
          check_field("present", 32'(want.present), 32'(out_rsp_o.present));
          check_field("position", 32'(want.position), 32'(out_rsp_o.position));
          check_field("moved_from", 32'(want.moved_from), 32'(out_rsp_o.moved_from));
          check_field("moved_to", 32'(want.moved_to), 32'(out_rsp_o.moved_to));
          check_field("live_count", 32'(want.live_count), 32'(out_rsp_o.live_count));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        got = update_table(in_req_i);
        pending_rsp_q.push_back(rsp_typed ? typed_rsp : got);
      end
    end
  end

  // watchdog: any handshake restarts the count
  int idle_run = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= WATCHDOG) begin
      $display("handle_slot_map regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request, none when quiet
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // stimulus
  initial begin
    hsm_req_t req;

    // shadow table reset
    gen_step = STEP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_hdl[i] = 32'(i);
      slot_alive[i] = 1'b0;
      slot_pos[i] = 0;
      slot_next[i] = i + 1;
      dense_hdl[i] = '0;
    end
    live_n = 0;
    head_slot = 0;
    tail_slot = SLOTS - 1;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk; the first request waits out the clearing pass
    foreach (directed_plan[i]) begin
      rsp_typed = directed_plan[i].typed;
      typed_rsp = directed_plan[i].rsp;
      req.op = directed_plan[i].op;
      req.handle = directed_plan[i].handle;
      send_req(req, pick_gap());
    end
    rsp_typed = 1'b0;

    // balanced mix at a random step, with a long receiver hold-off and a
    // sender pause until the block has drained
    settle();
    set_step(STEP_W'($urandom_range(2, 65534)));
    for (int i = 0; i < 150; i++) begin
      if (i == 40) hold_ask = HOLD_OFF;
      if (i == 100) settle();
      send_req(pick_req(45), pick_gap());
    end

    // zero step: reissued handles repeat; first stretch runs flat out
    settle();
    set_step('0);
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 50) quiet = 1'b0;
      send_req(pick_req(50), pick_gap());
    end

    // largest step: generations wrap; fill the table, then churn at the top
    // so full appends and removes from a full table both occur
    settle();
    set_step('1);
    while (live_n < SLOTS) send_req(pick_req(90), pick_gap());
    for (int i = 0; i < 60; i++) send_req(pick_req(50), pick_gap());

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("handle_slot_map regression: pass");
    end else begin
      $display("handle_slot_map regression: fail");
    end
    $finish;
  end

endmodule
